/* design/orf_stream_finder_defines.svh */
// Assertion macros shared by the ORF stream finder RTL.
`ifndef ORF_STREAM_FINDER_DEFINES_SVH
`define ORF_STREAM_FINDER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define ORF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ORF finder check failed one cycle after its trigger");

// The consequent must hold in the same cycle as the antecedent.
`define ORF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ORF finder check failed in the cycle of its trigger");

`endif

/* design/orf_pkg.sv */
// Shared types, widths and constants of the ORF stream finder.
`default_nettype none

package orf_pkg;

	localparam int NUC_W = 3;
	localparam int SEQ_W = 20;
	localparam int POS_OUT_W = 25;
	localparam int CODON_W = 6;
	localparam int MIN_BODY_W = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_STOPS = 4;
	localparam int NUM_FRAMES = 3;

	localparam int DEF_MAX_LEN_BITS = 24;
	localparam int DEF_PENDING_DEPTH = 16;
	localparam int DEF_SEQ_ID_BITS = 20;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_START_CODON = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_D = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_ENABLE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BODY = 3'd6;

	localparam logic [CODON_W-1:0] RST_START_CODON = 6'd14;
	localparam logic [CODON_W-1:0] RST_STOP_A = 6'd48;
	localparam logic [CODON_W-1:0] RST_STOP_B = 6'd50;
	localparam logic [CODON_W-1:0] RST_STOP_C = 6'd56;
	localparam logic [CODON_W-1:0] RST_STOP_D = 6'd0;
	localparam logic [NUM_STOPS-1:0] RST_STOP_ENABLE = 4'd7;
	localparam logic [MIN_BODY_W-1:0] RST_MIN_BODY = 24'd0;

	typedef struct packed {
		logic [CODON_W-1:0] start_codon;
		logic [NUM_STOPS-1:0][CODON_W-1:0] stop_codon;
		logic [NUM_STOPS-1:0] stop_enable;
		logic [MIN_BODY_W-1:0] min_body;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
		logic k_clr;
		logic k_inc;
		logic rd;
		logic take;
		logic flush;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan;
		logic entry_pass;
		logic k_last;
		logic hold_valid;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

/* design/orf_in_if.sv */
// Input channel of the ORF stream finder: one nucleotide per item.
`default_nettype none

interface orf_in_if;
	import orf_pkg::*;

	logic valid;
	logic ready;
	logic [NUC_W-1:0] nucleotide;
	logic [SEQ_W-1:0] seq_number;
	logic end_of_sequence;

	modport source (output valid, nucleotide, seq_number, end_of_sequence, input ready);
	modport sink (input valid, nucleotide, seq_number, end_of_sequence, output ready);
endinterface

`default_nettype wire

/* design/orf_out_if.sv */
// Output channel of the ORF stream finder: one ORF record per item.
`default_nettype none

interface orf_out_if;
	import orf_pkg::*;

	logic valid;
	logic ready;
	logic [POS_OUT_W-1:0] orf_start;
	logic [POS_OUT_W-1:0] orf_end;
	logic [SEQ_W-1:0] orf_seq;
	logic starts_lost;
	logic last_record;

	modport source (output valid, orf_start, orf_end, orf_seq, starts_lost, last_record,
		input ready);
	modport sink (input valid, orf_start, orf_end, orf_seq, starts_lost, last_record,
		output ready);
endinterface

`default_nettype wire

/* design/orf_cfg_regs.sv */
// Configuration register file of the ORF stream finder.
`default_nettype none

module orf_cfg_regs (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [orf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [orf_pkg::CFG_DATA_W-1:0] cfg_data,
	output orf_pkg::cfg_t cfg
);
	import orf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_codon <= RST_START_CODON;
			cfg_q.stop_codon[0] <= RST_STOP_A;
			cfg_q.stop_codon[1] <= RST_STOP_B;
			cfg_q.stop_codon[2] <= RST_STOP_C;
			cfg_q.stop_codon[3] <= RST_STOP_D;
			cfg_q.stop_enable <= RST_STOP_ENABLE;
			cfg_q.min_body <= RST_MIN_BODY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_CODON: cfg_q.start_codon <= cfg_data[CODON_W-1:0];
				REG_STOP_A: cfg_q.stop_codon[0] <= cfg_data[CODON_W-1:0];
				REG_STOP_B: cfg_q.stop_codon[1] <= cfg_data[CODON_W-1:0];
				REG_STOP_C: cfg_q.stop_codon[2] <= cfg_data[CODON_W-1:0];
				REG_STOP_D: cfg_q.stop_codon[3] <= cfg_data[CODON_W-1:0];
				REG_STOP_ENABLE: cfg_q.stop_enable <= cfg_data[NUM_STOPS-1:0];
				REG_MIN_BODY: cfg_q.min_body <= cfg_data[MIN_BODY_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* design/orf_ctrl.sv */
// Controller state machine: sequences evaluation, start-list scan and record flush.
`default_nettype none

module orf_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  orf_pkg::dp_status_t st,
	output orf_pkg::ctrl_cmd_t cmd
);
	import orf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (st.scan) begin
					cmd.k_clr = 1'b1;
					state_d = S_READ;
				end else begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				cmd.rd = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				// A passing entry waits while the held record cannot move out.
				if (!st.entry_pass || !st.hold_valid || st.out_free) begin
					cmd.take = st.entry_pass;
					if (st.k_last) begin
						state_d = S_FLUSH;
					end else begin
						cmd.k_inc = 1'b1;
						state_d = S_READ;
					end
				end
			end
			S_FLUSH: begin
				if (!st.hold_valid) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

`default_nettype wire

/* design/orf_datapath.sv */
// Datapath: base history, frame start lists in memory, record hold and output register.
`default_nettype none

module orf_datapath #(
	parameter int MAX_LEN_BITS = orf_pkg::DEF_MAX_LEN_BITS,
	parameter int PENDING_DEPTH = orf_pkg::DEF_PENDING_DEPTH,
	parameter int SEQ_ID_BITS = orf_pkg::DEF_SEQ_ID_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  orf_pkg::cfg_t cfg,
	input  wire logic [orf_pkg::NUC_W-1:0] nucleotide,
	input  wire logic [orf_pkg::SEQ_W-1:0] seq_number,
	input  wire logic end_of_sequence,
	input  orf_pkg::ctrl_cmd_t cmd,
	output orf_pkg::dp_status_t st,
	orf_out_if.source orfs
);
	import orf_pkg::*;

	localparam int PW = MAX_LEN_BITS + 1;
	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam int KW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int DEPTH_ALL = NUM_FRAMES * PENDING_DEPTH;
	localparam int AW = $clog2(DEPTH_ALL);
	localparam int DW = (PW > MIN_BODY_W) ? PW : MIN_BODY_W;
	localparam logic [SEQ_W-1:0] SEQ_MASK = (SEQ_ID_BITS >= SEQ_W) ? '1 :
		SEQ_W'((64'd1 << SEQ_ID_BITS) - 64'd1);

	// Latched item.
	logic [NUC_W-1:0] item_nuc_q;
	logic [SEQ_W-1:0] item_seq_q;
	logic item_eos_q;

	// Stream state.
	logic [PW-1:0] pos_q;
	logic [1:0] pmod_q;
	logic [2*NUC_W-1:0] prev_q;
	logic [1:0] seen_q;
	logic [CW-1:0] cnt_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] lost_q;
	logic [KW-1:0] k_q;

	logic [MAX_LEN_BITS-1:0] mem [DEPTH_ALL];
	logic [MAX_LEN_BITS-1:0] rd_data_q;

	logic hold_valid_q;
	logic [POS_OUT_W-1:0] hold_start_q;
	logic hold_lost_q;

	logic out_valid_q;
	logic [POS_OUT_W-1:0] out_start_q;
	logic [POS_OUT_W-1:0] out_end_q;
	logic [SEQ_W-1:0] out_seq_q;
	logic out_lost_q;
	logic out_last_q;

	logic in_range;
	logic codon_ok;
	logic [CODON_W-1:0] codon;
	logic is_stop;
	logic is_start;
	logic [MAX_LEN_BITS-1:0] s_pos;
	logic [1:0] frame;
	logic [CW-1:0] cnt_f;
	logic [CW-1:0] base_cnt;
	logic [CW-1:0] cnt_next;
	logic lost_next;
	logic mem_we;
	logic [AW-1:0] frame_base;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [PW-1:0] s_ext;
	logic [PW-1:0] st_end;
	logic [PW-1:0] body;
	logic [PW-1:0] end_ext;
	logic [PW-1:0] start_ext;
	logic entry_pass;
	logic out_free;
	logic out_load;

	assign in_range = !pos_q[MAX_LEN_BITS];
	assign codon = {prev_q[4:3], prev_q[1:0], item_nuc_q[1:0]};
	assign codon_ok = in_range && seen_q[1] && !prev_q[5] && !prev_q[2] && !item_nuc_q[2];

	always_comb begin
		is_stop = 1'b0;
		for (int i = 0; i < NUM_STOPS; i++) begin
			if (cfg.stop_enable[i] && (codon == cfg.stop_codon[i])) begin
				is_stop = 1'b1;
			end
		end
		is_stop = is_stop && codon_ok;
	end

	assign is_start = codon_ok && (codon == cfg.start_codon);
	assign s_pos = pos_q[MAX_LEN_BITS-1:0] - MAX_LEN_BITS'(2);

	// The codon starts two bases back, so its frame is (position + 1) mod 3.
	always_comb begin
		unique case (pmod_q)
			2'd0: frame = 2'd1;
			2'd1: frame = 2'd2;
			default: frame = 2'd0;
		endcase
	end

	assign cnt_f = cnt_q[frame];
	assign base_cnt = is_stop ? '0 : cnt_f;

	always_comb begin
		cnt_next = base_cnt;
		lost_next = is_stop ? 1'b0 : lost_q[frame];
		if (is_start) begin
			if (base_cnt < CW'(PENDING_DEPTH)) begin
				cnt_next = base_cnt + CW'(1);
			end else begin
				lost_next = 1'b1;
			end
		end
	end

	assign frame_base = AW'(int'(frame) * PENDING_DEPTH);
	assign rd_addr = frame_base + AW'(k_q);
	assign wr_addr = frame_base + AW'(base_cnt);
	assign mem_we = cmd.commit && is_start && (base_cnt < CW'(PENDING_DEPTH));

	// Body length test of the entry that was read.
	assign s_ext = {1'b0, s_pos};
	assign st_end = {1'b0, rd_data_q} + PW'(3);
	assign body = s_ext - st_end;
	assign entry_pass = (s_ext >= st_end) && (DW'(body) >= DW'(cfg.min_body));
	assign end_ext = s_ext + PW'(3);
	assign start_ext = {1'b0, rd_data_q} + PW'(1);

	assign out_free = !out_valid_q || orfs.ready;
	assign out_load = cmd.flush || (cmd.take && hold_valid_q);

	assign st.scan = is_stop && (cnt_f != '0);
	assign st.entry_pass = entry_pass;
	assign st.k_last = ((CW'(k_q) + CW'(1)) == cnt_f);
	assign st.hold_valid = hold_valid_q;
	assign st.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_nuc_q <= nucleotide;
			item_seq_q <= seq_number & SEQ_MASK;
			item_eos_q <= end_of_sequence;
		end
		if (cmd.take) begin
			hold_start_q <= POS_OUT_W'(start_ext);
			hold_lost_q <= lost_q[frame];
		end
		if (out_load) begin
			out_start_q <= hold_start_q;
			out_end_q <= POS_OUT_W'(end_ext);
			out_seq_q <= item_seq_q;
			out_lost_q <= hold_lost_q;
			out_last_q <= cmd.flush;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= s_pos;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			pmod_q <= '0;
			prev_q <= '0;
			seen_q <= '0;
			lost_q <= '0;
			k_q <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cmd.k_clr) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + KW'(1);
			end

			if (cmd.take) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_valid_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (orfs.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.commit) begin
				if (item_eos_q) begin
					pos_q <= '0;
					pmod_q <= '0;
					prev_q <= '0;
					seen_q <= '0;
					lost_q <= '0;
					for (int i = 0; i < NUM_FRAMES; i++) begin
						cnt_q[i] <= '0;
					end
				end else if (in_range) begin
					prev_q <= {prev_q[NUC_W-1:0], item_nuc_q};
					if (!seen_q[1]) begin
						seen_q <= seen_q + 2'd1;
					end
					pos_q <= pos_q + PW'(1);
					pmod_q <= (pmod_q == 2'd2) ? 2'd0 : pmod_q + 2'd1;
					if (codon_ok) begin
						cnt_q[frame] <= cnt_next;
						lost_q[frame] <= lost_next;
					end
				end
			end
		end
	end

	assign orfs.valid = out_valid_q;
	assign orfs.orf_start = out_start_q;
	assign orfs.orf_end = out_end_q;
	assign orfs.orf_seq = out_seq_q;
	assign orfs.starts_lost = out_lost_q;
	assign orfs.last_record = out_last_q;

endmodule

`default_nettype wire

/* design/orf_stream_finder.sv */
// An item that completes no stop codon, or one in a frame with no open starts, is accepted,
// then evaluated and updated. A stop codon in a frame with open starts is accepted and
// evaluated, then gets one start-list memory read and one length check per open start, then the final record flush.
// Records leave through an output register; a stalled output holds the scan.
// Asynchronous reset clears the stream state and loads the default codon registers.
`default_nettype none

`include "orf_stream_finder_defines.svh"

module orf_stream_finder #(
	parameter int MAX_LEN_BITS = orf_pkg::DEF_MAX_LEN_BITS,
	parameter int PENDING_DEPTH = orf_pkg::DEF_PENDING_DEPTH,
	parameter int SEQ_ID_BITS = orf_pkg::DEF_SEQ_ID_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [orf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [orf_pkg::CFG_DATA_W-1:0] cfg_data,
	orf_in_if.sink bases,
	orf_out_if.source orfs
);
	import orf_pkg::*;

	cfg_t cfg;
	ctrl_cmd_t cmd;
	dp_status_t st;
	logic in_ready;

	orf_cfg_regs u_cfg (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data (cfg_data),
		.cfg (cfg)
	);

	orf_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (bases.valid),
		.in_ready (in_ready),
		.st (st),
		.cmd (cmd)
	);

	orf_datapath #(
		.MAX_LEN_BITS (MAX_LEN_BITS),
		.PENDING_DEPTH (PENDING_DEPTH),
		.SEQ_ID_BITS (SEQ_ID_BITS)
	) u_dp (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg),
		.nucleotide (bases.nucleotide),
		.seq_number (bases.seq_number),
		.end_of_sequence (bases.end_of_sequence),
		.cmd (cmd),
		.st (st),
		.orfs (orfs)
	);

	assign bases.ready = in_ready;

	`ORF_ASSERT_NEXT(a_accept_busy, bases.valid && bases.ready, !bases.ready)
	`ORF_ASSERT_NEXT(a_commit_idle, cmd.commit, bases.ready)
	`ORF_ASSERT_NEXT(a_flush_last, cmd.flush, orfs.valid && orfs.last_record)
	`ORF_ASSERT_NEXT(a_take_not_last, cmd.take && st.hold_valid,
		orfs.valid && !orfs.last_record)
	`ORF_ASSERT_SAME(a_hold_in_scan, st.hold_valid, !bases.ready)

endmodule

`default_nettype wire
